### hdl/arcp_pkg.sv
// Shared widths, constants, types and helper functions of the ring cursor pixel pipeline.
package arcp_pkg;

    localparam int SIZE          = 48;
    localparam int PIX_W         = 7;
    localparam int LEVEL_W       = 4;
    localparam int ARGB_W        = 32;
    localparam int CH_W          = 8;
    localparam int COV_W         = 9;
    localparam int RADIUS_W      = 13;

    localparam int MAG_W         = $clog2(SIZE);
    localparam int SUM_W         = 2 * MAG_W + 1;
    localparam int SCALE_SH      = 14;
    localparam int SQ_W          = SUM_W + SCALE_SH;
    localparam int SQ_ITER       = (SQ_W + 1) / 2;
    localparam int ITER_PER_STG  = 4;
    localparam int SQRT_STG      = (SQ_ITER + ITER_PER_STG - 1) / ITER_PER_STG;
    localparam int ROOT_W        = SQRT_STG * ITER_PER_STG;
    localparam int RADIC_W       = 2 * ROOT_W;
    localparam int REM_W         = ROOT_W + 3;
    localparam int DIST_W        = ROOT_W + 1;
    localparam int EDGE_W        = (DIST_W > RADIUS_W) ? DIST_W : RADIUS_W;

    localparam int ST_SQ         = 0;
    localparam int ST_RND        = SQRT_STG + 1;
    localparam int ST_EDGE       = SQRT_STG + 2;
    localparam int ST_ALPHA      = SQRT_STG + 3;
    localparam int ST_OUT        = SQRT_STG + 4;
    localparam int NSTG          = SQRT_STG + 5;

    localparam logic [EDGE_W-1:0] OUTLINE_REACH = EDGE_W'(998);
    localparam logic [EDGE_W-1:0] CORE_REACH    = EDGE_W'(640);
    localparam logic [COV_W-1:0]  ONE_Q8        = COV_W'(256);
    localparam int                OUTLINE_GAIN  = 243 * 255;
    localparam logic [CH_W-1:0]   ALPHA_MAX     = 8'd255;
    localparam logic [CH_W-1:0]   DARK_R        = 8'd18;
    localparam logic [CH_W-1:0]   DARK_G        = 8'd20;
    localparam logic [CH_W-1:0]   DARK_B        = 8'd19;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic [RADIC_W-1:0] rad;
        logic               in_square;
    } t_sqrt_st;

    // one restoring square-root digit
    function automatic t_sqrt_st sqrt_step(input t_sqrt_st s);
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        t_sqrt_st         o;
        o     = s;
        cur   = {s.rem[REM_W-3:0], s.rad[RADIC_W-1 -: 2]};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
        if (cur >= trial) begin
            o.rem  = cur - trial;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = cur;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        o.rad = {s.rad[RADIC_W-3:0], 2'b00};
        return o;
    endfunction

    // ring radius in Q8, level saturates at twelve
    function automatic logic [RADIUS_W-1:0] ring_radius(input logic [LEVEL_W-1:0] level);
        logic [RADIUS_W-1:0] r;
        case (level)
            4'd0:    r = 13'd1280;
            4'd1:    r = 13'd1557;
            4'd2:    r = 13'd1835;
            4'd3:    r = 13'd2112;
            4'd4:    r = 13'd2389;
            4'd5:    r = 13'd2667;
            4'd6:    r = 13'd2944;
            4'd7:    r = 13'd3221;
            4'd8:    r = 13'd3499;
            4'd9:    r = 13'd3776;
            4'd10:   r = 13'd4053;
            4'd11:   r = 13'd4331;
            default: r = 13'd4608;
        endcase
        return r;
    endfunction

    // (c*a+127)/255 via the divide-by-255 identity
    function automatic logic [CH_W-1:0] premul(input logic [CH_W-1:0] c,
                                               input logic [CH_W-1:0] a);
        logic [15:0] x;
        logic [16:0] y;
        x = 16'(c) * 16'(a) + 16'd127;
        y = 17'(x) + 17'd1 + 17'(x[15:8]);
        return y[15:8];
    endfunction

endpackage

### hdl/antialiased_ring_cursor_pixel.sv
// Top level: pipelined anti-aliased ring cursor pixel generator, premultiplied ARGB out.
//
// Input channel: i_valid / o_ready carry one pixel beat (i_pixel_x, i_pixel_y).
// Output channel: o_valid / i_ready carry one result beat (o_argb), one per input beat,
// in order. Alpha sits in bits 31:24; red, green and blue are premultiplied.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data to the aperture level on the next
// rising edge; write only while the pipeline holds no beats. Levels above twelve act
// as twelve.
// Throughput: one beat per cycle unless a stall on i_ready fills every stage; the
// square root runs as SQRT_STG stages of four digits each, the remaining stages are
// one register each.
// Reset (synchronous, active low): all stage valid bits clear, aperture level goes
// to zero, o_valid drops.
// Stall: when i_ready is low, the output register holds its beat; upstream stages
// keep filling bubbles and o_ready drops only when every stage is occupied.
// Pixels outside the square, and outside the ring outline, give zero.
module antialiased_ring_cursor_pixel
    import arcp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [LEVEL_W-1:0]   i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PIX_W-1:0]     i_pixel_x,
    input  logic [PIX_W-1:0]     i_pixel_y,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ARGB_W-1:0]    o_argb
);

    logic [LEVEL_W-1:0] r_level;
    logic [NSTG-1:0]    r_vld;
    logic [NSTG-1:0]    en;

    // square stage
    logic [PIX_W+1:0]   twx, twy, kx, ky, sz9;
    logic [MAG_W-1:0]   mag_x, mag_y;
    logic [SUM_W-1:0]   n_sum;
    logic               n_inside;
    t_sqrt_st           r_sq;

    // root stages
    t_sqrt_st           r_rt [SQRT_STG];
    t_sqrt_st           n_rt [SQRT_STG];

    // rounding stage
    logic [DIST_W-1:0]  r_dist;
    logic               r_rnd_in;

    // edge stage
    logic [EDGE_W-1:0]  edge_q8, radius_ext;
    logic [EDGE_W-1:0]  out_diff, core_diff;
    logic [COV_W-1:0]   r_outline, r_core;
    logic               r_e_on, r_e_core;

    // alpha stage
    logic [16:0]        core_prod;
    logic [23:0]        outl_prod;
    logic [CH_W-1:0]    n_alpha;
    logic [CH_W-1:0]    r_alpha;
    logic               r_a_on, r_a_core;

    // output stage
    logic [ARGB_W-1:0]  n_argb;
    logic [ARGB_W-1:0]  r_argb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cfg_wr_en) begin
            r_level <= i_cfg_wr_data;
        end
    end

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_argb  = r_argb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // centre offsets, squared distance
    always_comb begin
        sz9      = (PIX_W+2)'(SIZE);
        twx      = {1'b0, i_pixel_x, 1'b1};
        twy      = {1'b0, i_pixel_y, 1'b1};
        kx       = (twx >= sz9) ? twx - sz9 : sz9 - twx;
        ky       = (twy >= sz9) ? twy - sz9 : sz9 - twy;
        mag_x    = kx[MAG_W-1:0];
        mag_y    = ky[MAG_W-1:0];
        n_sum    = SUM_W'(mag_x * mag_x) + SUM_W'(mag_y * mag_y);
        n_inside = ({1'b0, i_pixel_x} < (PIX_W+1)'(SIZE)) &&
                   ({1'b0, i_pixel_y} < (PIX_W+1)'(SIZE));
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_SQ]) begin
            r_sq.rem       <= '0;
            r_sq.root      <= '0;
            r_sq.rad       <= RADIC_W'({n_sum, {SCALE_SH{1'b0}}});
            r_sq.in_square <= n_inside;
        end
    end

    // four root digits per stage
    for (genvar s = 0; s < SQRT_STG; s++) begin : g_root
        always_comb begin
            t_sqrt_st cur;
            cur = (s == 0) ? r_sq : r_rt[(s == 0) ? 0 : s-1];
            for (int j = 0; j < ITER_PER_STG; j++) begin
                cur = sqrt_step(cur);
            end
            n_rt[s] = cur;
        end

        always_ff @(posedge i_clk) begin
            if (en[s+1]) begin
                r_rt[s] <= n_rt[s];
            end
        end
    end

    // round to nearest
    always_ff @(posedge i_clk) begin
        if (en[ST_RND]) begin
            r_rnd_in <= r_rt[SQRT_STG-1].in_square;
            if (r_rt[SQRT_STG-1].rem > REM_W'(r_rt[SQRT_STG-1].root)) begin
                r_dist <= DIST_W'(r_rt[SQRT_STG-1].root) + DIST_W'(1);
            end else begin
                r_dist <= DIST_W'(r_rt[SQRT_STG-1].root);
            end
        end
    end

    // distance from ring edge, coverages
    always_comb begin
        radius_ext = EDGE_W'(ring_radius(r_level));
        edge_q8    = (EDGE_W'(r_dist) >= radius_ext) ? EDGE_W'(r_dist) - radius_ext
                                                     : radius_ext - EDGE_W'(r_dist);
        out_diff   = OUTLINE_REACH - edge_q8;
        core_diff  = CORE_REACH - edge_q8;
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_EDGE]) begin
            r_e_on    <= r_rnd_in && (edge_q8 < OUTLINE_REACH);
            r_e_core  <= edge_q8 < CORE_REACH;
            r_outline <= (out_diff > EDGE_W'(ONE_Q8)) ? ONE_Q8 : out_diff[COV_W-1:0];
            r_core    <= (core_diff > EDGE_W'(ONE_Q8)) ? ONE_Q8 : core_diff[COV_W-1:0];
        end
    end

    // alpha
    always_comb begin
        core_prod = 17'(r_core) * 17'd255 + 17'd128;
        outl_prod = 24'(r_outline) * 24'(OUTLINE_GAIN) + 24'd32768;
        if (r_e_core) begin
            n_alpha = core_prod[16] ? ALPHA_MAX : core_prod[15:8];
        end else begin
            n_alpha = outl_prod[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_ALPHA]) begin
            r_alpha  <= n_alpha;
            r_a_on   <= r_e_on;
            r_a_core <= r_e_core;
        end
    end

    // premultiply and pack
    always_comb begin
        if (!r_a_on) begin
            n_argb = '0;
        end else if (r_a_core) begin
            n_argb = {r_alpha, r_alpha, r_alpha, r_alpha};
        end else begin
            n_argb = {r_alpha, premul(DARK_R, r_alpha), premul(DARK_G, r_alpha),
                      premul(DARK_B, r_alpha)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_argb <= n_argb;
        end
    end

endmodule

### hdl/arcp_chk.sv
// Port-level checker for the ring cursor pixel block, bound to the top level.
module arcp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_argb
);

    a_rst_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped under stall");

    a_argb_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_argb))
        else $error("result beat changed under stall");

    a_premultiplied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_argb[23:16] <= o_argb[31:24]) && (o_argb[15:8] <= o_argb[31:24])
                    && (o_argb[7:0] <= o_argb[31:24]))
        else $error("colour channel above alpha");

endmodule

bind antialiased_ring_cursor_pixel arcp_chk u_arcp_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_argb  (o_argb)
);
